>>> sv/hsha_pkg.sv
// ----------------------------------------------------------------------------
// hsha_pkg
// shared types, constants and round functions of the hmac-sha1 unit
// ----------------------------------------------------------------------------
package hsha_pkg;

	localparam int LengthBits = 32;
	localparam int CountW     = LengthBits - 3;
	localparam logic [CountW-1:0] CountMax = CountW'((64'd1 << CountW) - 64'd65);

	localparam logic [7:0] Ipad     = 8'h36;
	localparam logic [7:0] Opad     = 8'h5c;
	localparam int         TagBytes = 20;
	localparam int         OuterLen = 84;

	localparam logic [159:0] ShaIv = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
		32'h10325476, 32'hC3D2E1F0};

	// queued item from front to back
	typedef struct packed {
		logic       action;
		logic [7:0] data;
		logic       last;
		logic       check;
	} item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] tag;
		logic       last;
		logic       match;
	} result_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] t);
		logic [31:0] k;
		if (t < 7'd20)      k = 32'h5A827999;
		else if (t < 7'd40) k = 32'h6ED9EBA1;
		else if (t < 7'd60) k = 32'h8F1BBCDC;
		else                k = 32'hCA62C1D6;
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (t < 7'd20)      f = (b & c) | (~b & d);
		else if (t < 7'd40) f = b ^ c ^ d;
		else if (t < 7'd60) f = (b & c) | (b & d) | (c & d);
		else                f = b ^ c ^ d;
		return f;
	endfunction

endpackage

>>> sv/hmac_sha1_tag_and_verify_unit.sv
// ----------------------------------------------------------------------------
// hmac_sha1_tag_and_verify_unit
// hmac-sha1 with a 64-byte register key; emits a 20-byte tag or checks one
// ----------------------------------------------------------------------------
// The first byte of a message loads the inner key block, runs the rounds of
// the single sha-1 round unit and one add, and then absorbs the held byte.
// Other message bytes shift in while idle, and the byte that fills a 64-byte
// block starts a run of rounds. The last byte adds the padding block (and a
// second one when the length spills into a second block), an opad wait state
// and the two outer blocks; then come 20 tag beats, or the unit waits for 20
// expected tag beats and sends one verdict.
module hmac_sha1_tag_and_verify_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tlast,   // last_byte
	input  logic [1:0]  s_axis_tuser,   // action, check_tag
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // tag_byte, match, zero fill
	output logic        m_axis_tlast,   // tag_last
	output logic        m_axis_tuser,   // result_kind
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import hsha_pkg::*;

	logic [63:0] key_q [8];
	logic [511:0] key;
	item_t   in_item, q_item;
	result_t r_data;
	logic    q_valid, q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) key_q[i] <= '0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	assign key = {key_q[0], key_q[1], key_q[2], key_q[3], key_q[4], key_q[5],
		key_q[6], key_q[7]};
	assign in_item = '{action: s_axis_tuser[0], data: s_axis_tdata,
		last: s_axis_tlast, check: s_axis_tuser[1]};

	hsha_front u_front (
		.clk, .arst_n,
		.in_valid (s_axis_tvalid), .in_ready (s_axis_tready), .in_item,
		.q_valid, .q_ready, .q_item
	);

	hsha_back u_back (
		.clk, .arst_n, .key,
		.q_valid, .q_ready, .q_item,
		.r_valid (m_axis_tvalid), .r_ready (m_axis_tready), .r_data
	);

	assign m_axis_tdata = {7'd0, r_data.match, r_data.tag};
	assign m_axis_tlast = r_data.last;
	assign m_axis_tuser = r_data.kind;
endmodule

>>> sv/hsha_front.sv
// ----------------------------------------------------------------------------
// hsha_front
// input stage with a two-entry queue that decouples the stream from the hash core
// ----------------------------------------------------------------------------
module hsha_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hsha_pkg::item_t      in_item,
	output logic                 q_valid,
	input  logic                 q_ready,
	output hsha_pkg::item_t      q_item
);
	import hsha_pkg::*;

	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !pop) else $error("pop from empty queue");
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !in_ready) else $error("ready while full");
endmodule

>>> sv/hsha_back.sv
// ----------------------------------------------------------------------------
// hsha_back
// hmac-sha1 sequencer: byte absorb, one sha-1 round per cycle, tag out and check
// ----------------------------------------------------------------------------
module hsha_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [511:0]         key,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  hsha_pkg::item_t      q_item,
	output logic                 r_valid,
	input  logic                 r_ready,
	output hsha_pkg::result_t    r_data
);
	import hsha_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LOAD  = 4'd1;  // fill block from a source
	localparam logic [3:0] S_RND   = 4'd2;
	localparam logic [3:0] S_ADD   = 4'd3;
	localparam logic [3:0] S_EMIT  = 4'd4;
	localparam logic [3:0] S_OPADW = 4'd5;
	// block sources
	localparam logic [2:0] B_IPAD  = 3'd0;
	localparam logic [2:0] B_FIN1  = 3'd2;  // pad block, length fits
	localparam logic [2:0] B_FIN2  = 3'd3;  // pad block, length spills
	localparam logic [2:0] B_LEN   = 3'd4;  // zeros plus length
	localparam logic [2:0] B_OPAD  = 3'd5;
	localparam logic [2:0] B_OUTER = 3'd6;
	// after-compress continuations
	localparam logic [2:0] N_MSG   = 3'd0;
	localparam logic [2:0] N_OPAD  = 3'd1;
	localparam logic [2:0] N_OUTER = 3'd2;
	localparam logic [2:0] N_DONE  = 3'd3;
	localparam logic [2:0] N_LEN   = 3'd4;
	localparam logic [2:0] N_IPAD  = 3'd5;

	localparam logic [1:0] P_IDLE  = 2'd0;
	localparam logic [1:0] P_MSG   = 2'd1;
	localparam logic [1:0] P_AWAIT = 2'd2;

	logic [3:0]   state_q;
	logic [1:0]   phase_q;
	logic [2:0]   nxt_q;
	logic [5:0]   fill_q;
	logic [CountW-1:0] count_q;
	logic         last_q, check_q;
	logic [7:0]   first_q;
	logic [31:0]  w_q [16];
	logic [159:0] cv_q;
	logic [159:0] inner_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [6:0]   t_q;
	logic [4:0]   tidx_q;
	logic         mis_q;
	logic [5:0]   li_q;
	logic [2:0]   src_q;
	logic [7:0]   lbyte;
	logic [63:0]  len_inner;
	logic [31:0]  wt, wn, tmp;
	logic [7:0]   dig;
	logic         r_busy;
	logic         msg_take;
	logic         r_load;

	assign len_inner = ({{(64-CountW){1'b0}}, count_q} + 64'd64) << 3;
	assign dig = cv_q[159 - 8*tidx_q -: 8];
	assign r_busy = r_valid && !r_ready;

	always_comb begin
		logic [7:0] kb;
		logic [63:0] ln;
		kb = key[511 - 8*li_q -: 8];
		ln = (src_q == B_OUTER) ? 64'(OuterLen * 8) : len_inner;
		lbyte = 8'h00;
		case (src_q)
			B_IPAD: lbyte = kb ^ Ipad;
			B_OPAD: lbyte = kb ^ Opad;
			B_OUTER: begin
				if (li_q < 6'(TagBytes)) lbyte = inner_q[159 - 8*li_q -: 8];
				else if (li_q == 6'(TagBytes)) lbyte = 8'h80;
				else if (li_q >= 6'd56) lbyte = ln[63 - 8*(li_q - 6'd56) -: 8];
			end
			B_FIN1, B_FIN2: begin
				if (li_q == fill_q) lbyte = 8'h80;
				else if (src_q == B_FIN1 && li_q >= 6'd56)
					lbyte = ln[63 - 8*(li_q - 6'd56) -: 8];
			end
			B_LEN: if (li_q >= 6'd56) lbyte = ln[63 - 8*(li_q - 6'd56) -: 8];
			default: lbyte = 8'h00;
		endcase
	end

	always_comb begin
		if (t_q < 7'd16) wt = w_q[t_q[3:0]];
		else wt = rotl(w_q[4'(t_q + 7'd13)] ^ w_q[4'(t_q + 7'd8)]
			^ w_q[4'(t_q + 7'd2)] ^ w_q[t_q[3:0]], 5'd1);
		wn = wt;
		tmp = rotl(a_q, 5'd5) + round_f(t_q, b_q, c_q, d_q) + e_q + round_k(t_q) + wt;
	end

	assign q_ready = (state_q == S_IDLE) && !r_busy;
	assign msg_take = (state_q == S_IDLE) && q_valid && q_ready && !q_item.action
		&& (phase_q == P_MSG);
	assign r_load = ((state_q == S_IDLE) && q_valid && q_ready && q_item.action
		&& (phase_q == P_AWAIT) && (tidx_q == 5'(TagBytes - 1)))
		|| ((state_q == S_EMIT) && !r_busy);

	// message bytes shift straight into the schedule words
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			w_q[li_q[5:2]] <= {w_q[li_q[5:2]][23:0], lbyte};
		end else if (state_q == S_RND) begin
			w_q[t_q[3:0]] <= wn;
		end else if (state_q == S_ADD && nxt_q == N_IPAD) begin
			w_q[0] <= {24'd0, first_q};
		end else if (msg_take) begin
			w_q[fill_q[5:2]] <= {w_q[fill_q[5:2]][23:0], q_item.data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= P_IDLE;
			nxt_q   <= N_MSG;
			src_q   <= B_IPAD;
			fill_q  <= '0;
			count_q <= '0;
			last_q  <= 1'b0;
			check_q <= 1'b0;
			first_q <= '0;
			cv_q    <= ShaIv;
			inner_q <= '0;
			t_q     <= '0;
			li_q    <= '0;
			tidx_q  <= '0;
			mis_q   <= 1'b0;
			r_valid <= 1'b0;
			r_data  <= '0;
			{a_q, b_q, c_q, d_q, e_q} <= '0;
		end else begin
			if (r_valid && r_ready && !r_load) r_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_valid && q_ready) begin
					if (q_item.action) begin
						if (phase_q == P_AWAIT) begin
							if (tidx_q == 5'(TagBytes - 1)) begin
								r_valid <= 1'b1;
								r_data  <= '{kind: 1'b1, tag: 8'h00, last: 1'b1,
									match: !(mis_q || q_item.data != dig)};
								phase_q <= P_IDLE;
								tidx_q  <= '0;
								mis_q   <= 1'b0;
							end else begin
								tidx_q <= tidx_q + 5'd1;
								if (q_item.data != dig) mis_q <= 1'b1;
							end
						end
					end else if (phase_q == P_MSG) begin
						last_q  <= q_item.last;
						check_q <= q_item.check;
						if (count_q < CountMax) count_q <= count_q + 1'b1;
						fill_q <= fill_q + 6'd1;
						if (fill_q == 6'd63) begin
							state_q <= S_RND; t_q <= '0;
							{a_q, b_q, c_q, d_q, e_q} <= cv_q;
							nxt_q <= q_item.last ? N_LEN : N_MSG;
						end else if (q_item.last) begin
							src_q <= (fill_q >= 6'd55) ? B_FIN2 : B_FIN1;
							li_q <= fill_q + 6'd1; state_q <= S_LOAD;
							nxt_q <= (fill_q >= 6'd55) ? N_LEN : N_OPAD;
						end
					end else if (phase_q == P_IDLE) begin
						// first byte: run key block then take the byte
						cv_q <= ShaIv; src_q <= B_IPAD; li_q <= '0; state_q <= S_LOAD;
						nxt_q <= N_IPAD; phase_q <= P_MSG; count_q <= '0; fill_q <= '0;
						last_q <= q_item.last; check_q <= q_item.check;
						first_q <= q_item.data;
					end
				end
				S_LOAD: begin
					li_q <= li_q + 6'd1;
					if (li_q == 6'd63) begin
						state_q <= S_RND; t_q <= '0;
						{a_q, b_q, c_q, d_q, e_q} <= cv_q;
					end
				end
				S_RND: begin
					{a_q, b_q, c_q, d_q, e_q} <= {tmp, a_q, rotl(b_q, 5'd30), c_q, d_q};
					t_q <= t_q + 7'd1;
					if (t_q == 7'd79) state_q <= S_ADD;
				end
				S_ADD: begin
					cv_q <= {cv_q[159:128] + a_q, cv_q[127:96] + b_q, cv_q[95:64] + c_q,
						cv_q[63:32] + d_q, cv_q[31:0] + e_q};
					case (nxt_q)
						N_IPAD: begin
							// absorb the held first byte
							fill_q <= 6'd1;
							count_q <= CountW'(1);
							if (last_q) begin
								src_q <= B_FIN1; li_q <= 6'd1; state_q <= S_LOAD;
								nxt_q <= N_OPAD;
							end else begin
								state_q <= S_IDLE; nxt_q <= N_MSG;
							end
						end
						N_MSG: begin fill_q <= '0; state_q <= S_IDLE; end
						N_LEN: begin
							src_q <= (fill_q == 6'd0) ? B_FIN1 : B_LEN;
							li_q <= '0; state_q <= S_LOAD; nxt_q <= N_OPAD;
						end
						N_OPAD: begin
							inner_q <= {cv_q[159:128] + a_q, cv_q[127:96] + b_q,
								cv_q[95:64] + c_q, cv_q[63:32] + d_q, cv_q[31:0] + e_q};
							fill_q <= '0; li_q <= '0;
							state_q <= S_OPADW;
						end
						N_OUTER: begin
							src_q <= B_OUTER; li_q <= '0; state_q <= S_LOAD; nxt_q <= N_DONE;
						end
						default: begin
							fill_q <= '0; tidx_q <= '0; mis_q <= 1'b0;
							if (check_q) begin
								phase_q <= P_AWAIT; state_q <= S_IDLE;
							end else begin
								phase_q <= P_IDLE; state_q <= S_EMIT;
							end
						end
					endcase
				end
				S_OPADW: begin
					cv_q <= ShaIv; src_q <= B_OPAD; state_q <= S_LOAD; nxt_q <= N_OUTER;
				end
				S_EMIT: if (!r_busy) begin
					r_valid <= 1'b1;
					r_data  <= '{kind: 1'b0, tag: dig,
						last: (tidx_q == 5'(TagBytes - 1)), match: 1'b0};
					if (tidx_q == 5'(TagBytes - 1)) begin
						tidx_q <= '0; state_q <= S_IDLE;
					end else tidx_q <= tidx_q + 5'd1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_tidx: assert property (@(posedge clk) disable iff (!arst_n)
		tidx_q < 5'(TagBytes)) else $error("tag index overrun");
	a_round: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RND |-> t_q < 7'd80) else $error("round count overrun");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_data))
		else $error("result dropped");
endmodule
